FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned PathW = 7;
  localparam int unsigned StatW = 16;
  localparam int unsigned TimeW = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_FIND_CHK,
    S_DROP,
    S_HEAD,
    S_HEAD_CHK,
    S_POS,
    S_POS_CHK,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic idx_clr;    // idx <= 0
    logic idx_inc;    // idx <= idx + 1
    logic mark;       // mark <= idx (insert position)
    logic idx_top;    // idx <= total, read entry total - 1
    logic rd;         // read mem at rd address
    logic rd_next;    // read address idx + 1 instead of idx
    logic mv_down;    // write rd data to idx, read idx + 2 (drop shift)
    logic mv_up;      // write rd data to idx, read idx - 2 (insert shift)
    logic take_head;  // load new item from head data (re-file)
    logic put;        // write new item at idx
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic time_inc;
    logic disp_set;
    logic set_nf;
    logic set_full;
    logic done;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic idx_end;    // idx == total
    logic idx_last;   // idx + 1 == total
    logic idx_mark;   // idx == insert position
    logic path_hit;   // read path equals item path
    logic due_lt;     // read due < new due
    logic head_due;   // time >= read due
    logic full;
    logic empty;
    logic [1:0] op;
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/periodic_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// periodic task scheduler: table of periodic entries sorted by due time
// command channel: drive opcode and fields with start_i while busy_o is low;
//   the transfer happens at that edge and busy_o rises for the whole item
// result channel: done_o pulses one cycle carrying dispatched, path, station,
//   status and entry count; receiver cannot stall, so sample on done_o
// add, remove and tick walk the table with one memory read per cycle:
//   search plus removal shift, then position search plus insertion shift
//   for an add or a tick that re-files the head; clear skips the walk;
//   busy_o stays high through the done_o cycle, so the next transfer waits
//   until the item is done, and the table walk sets how long that is
// one item in flight at a time
// tick advances time first, then dispatches the head if due and re-files it
//   at due plus period, saturating
// reset clears the count, the time counter and the controller; entry
//   memory is left as is and only slots below the count are used
module periodic_task_scheduler_top #(
  parameter int unsigned MaxEntries = pts_pkg::MaxEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [pts_pkg::PathW-1:0] path_number_i,
  input  logic [pts_pkg::StatW-1:0] station_number_i,
  input  logic [pts_pkg::TimeW-1:0] first_time_i,
  input  logic [pts_pkg::TimeW-1:0] period_i,
  output logic                      done_o,
  output logic                      dispatched_o,
  output logic [pts_pkg::PathW-1:0] out_path_o,
  output logic [pts_pkg::StatW-1:0] out_station_o,
  output logic [1:0]                status_o,
  output logic [6:0]                entries_in_use_o
);
  import pts_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  pts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // entry memory, index, counters and compare logic
  pts_dp #(.MaxEntries(MaxEntries)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .path_number_i   (path_number_i),
    .station_number_i(station_number_i),
    .first_time_i    (first_time_i),
    .period_i        (period_i),
    .done_o          (done_o),
    .dispatched_o    (dispatched_o),
    .out_path_o      (out_path_o),
    .out_station_o   (out_station_o),
    .status_o        (status_o),
    .entries_in_use_o(entries_in_use_o)
  );

  // a result only ever closes an item in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result without item");
  // busy_o is low in the cycle after a result
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy after result");
  // dispatch only reported ok
  a_disp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dispatched_o |-> (status_o == ST_OK)) else $error("dispatch with error");
endmodule
`default_nettype wire

FILE: rtl/pts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  pts_pkg::sts_t sts_i,
  output pts_pkg::ctl_t ctl_o
);
  import pts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_FIND;
      S_FIND: begin
        case (sts_i.op)
          OP_CLEAR: state_d = S_DONE;
          OP_TICK:  state_d = S_HEAD;
          default:  state_d = sts_i.idx_end ? S_POS : S_FIND_CHK;
        endcase
        if (sts_i.op == OP_REMOVE && sts_i.idx_end) state_d = S_DONE;
        if (sts_i.op == OP_ADD && sts_i.idx_end && sts_i.full) state_d = S_DONE;
      end
      S_FIND_CHK: begin
        if (sts_i.path_hit) begin
          state_d = S_DROP;
        end else if (sts_i.idx_last) begin
          state_d = (sts_i.op == OP_REMOVE || sts_i.full) ? S_DONE : S_POS;
        end else begin
          state_d = S_FIND_CHK;
        end
      end
      S_DROP: begin
        if (sts_i.idx_last) state_d = (sts_i.op == OP_REMOVE) ? S_DONE : S_POS;
      end
      S_HEAD: state_d = sts_i.empty ? S_DONE : S_HEAD_CHK;
      S_HEAD_CHK: state_d = sts_i.head_due ? S_DROP : S_DONE;
      S_POS: state_d = sts_i.idx_end ? S_WRITE : S_POS_CHK;
      S_POS_CHK: begin
        if (!sts_i.due_lt) state_d = S_SHIFT;
        else if (sts_i.idx_last) state_d = S_WRITE;
      end
      S_SHIFT: if (sts_i.idx_mark) state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        ctl_o.latch = start_i;
        ctl_o.idx_clr = 1'b1;
        ctl_o.rd = 1'b1;
      end
      S_FIND: begin
        ctl_o.rd = 1'b1;
        if (sts_i.op == OP_CLEAR) ctl_o.cnt_clr = 1'b1;
        if (sts_i.op == OP_TICK) ctl_o.time_inc = 1'b1;
        if (sts_i.op == OP_REMOVE && sts_i.idx_end) ctl_o.set_nf = 1'b1;
        if (sts_i.op == OP_ADD && sts_i.idx_end && sts_i.full) ctl_o.set_full = 1'b1;
      end
      S_FIND_CHK: begin
        if (sts_i.path_hit) begin
          ctl_o.rd = 1'b1;
          ctl_o.rd_next = 1'b1;
        end else if (sts_i.idx_last) begin
          ctl_o.idx_clr = 1'b1;
          ctl_o.rd = 1'b1;
          if (sts_i.op == OP_REMOVE) ctl_o.set_nf = 1'b1;
          else if (sts_i.full) ctl_o.set_full = 1'b1;
        end else begin
          ctl_o.idx_inc = 1'b1;
          ctl_o.rd = 1'b1;
          ctl_o.rd_next = 1'b1;
        end
      end
      S_DROP: begin
        // rd data holds entry idx+1
        if (sts_i.idx_last) begin
          ctl_o.cnt_dec = 1'b1;
          ctl_o.idx_clr = 1'b1;
          ctl_o.rd = 1'b1;
        end else begin
          ctl_o.mv_down = 1'b1;
          ctl_o.rd = 1'b1;
        end
      end
      S_HEAD: ctl_o.rd = 1'b1;
      S_HEAD_CHK: begin
        if (sts_i.head_due) begin
          ctl_o.take_head = 1'b1;
          ctl_o.disp_set = 1'b1;
          ctl_o.rd = 1'b1;
          ctl_o.rd_next = 1'b1;
        end
      end
      S_POS: begin
        if (sts_i.idx_end) ctl_o.idx_top = 1'b1;
        else ctl_o.rd = 1'b1;
      end
      S_POS_CHK: begin
        if (!sts_i.due_lt) begin
          // keep pos in mark; shift from top
          ctl_o.mark = 1'b1;
          ctl_o.idx_top = 1'b1;
          ctl_o.rd = 1'b1;
        end else if (sts_i.idx_last) begin
          ctl_o.idx_top = 1'b1;
        end else begin
          ctl_o.idx_inc = 1'b1;
          ctl_o.rd = 1'b1;
          ctl_o.rd_next = 1'b1;
        end
      end
      S_SHIFT: begin
        // rd data holds entry idx-1
        if (!sts_i.idx_mark) begin
          ctl_o.mv_up = 1'b1;
          ctl_o.rd = 1'b1;
        end
      end
      S_WRITE: begin
        ctl_o.put = 1'b1;
        ctl_o.cnt_inc = 1'b1;
      end
      S_DONE: ctl_o.done = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/pts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pts_dp #(
  parameter int unsigned MaxEntries = pts_pkg::MaxEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pts_pkg::ctl_t             ctl_i,
  output pts_pkg::sts_t             sts_o,
  input  logic [1:0]                opcode_i,
  input  logic [pts_pkg::PathW-1:0] path_number_i,
  input  logic [pts_pkg::StatW-1:0] station_number_i,
  input  logic [pts_pkg::TimeW-1:0] first_time_i,
  input  logic [pts_pkg::TimeW-1:0] period_i,
  output logic                      done_o,
  output logic                      dispatched_o,
  output logic [pts_pkg::PathW-1:0] out_path_o,
  output logic [pts_pkg::StatW-1:0] out_station_o,
  output logic [1:0]                status_o,
  output logic [6:0]                entries_in_use_o
);
  import pts_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  typedef struct packed {
    logic [PathW-1:0] path;
    logic [StatW-1:0] stn;
    logic [TimeW-1:0] due;
    logic [TimeW-1:0] ival;
  } entry_t;

  entry_t mem_q [MaxEntries];
  entry_t rd_q, new_q;
  logic [1:0]       op_q;
  logic [CntW-1:0]  idx_q, cnt_q, mark_q;
  logic [TimeW-1:0] time_q;
  logic             disp_q;
  logic [1:0]       stat_q;
  logic [CntW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;
  logic [CntW:0]    idx_p1;
  logic [TimeW:0]   refile;

  assign idx_p1 = {1'b0, idx_q} + 1'b1;
  assign rd_addr = ctl_i.idx_clr ? '0 :
                   ctl_i.idx_top ? cnt_q - 1'b1 :
                   ctl_i.mv_down ? idx_q + CntW'(2) :
                   ctl_i.mv_up   ? idx_q - CntW'(2) :
                   ctl_i.idx_inc ? idx_p1[CntW-1:0] :
                   ctl_i.rd_next ? idx_p1[CntW-1:0] : idx_q;
  assign wr_addr = idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd && rd_addr < CntW'(MaxEntries)) rd_q <= mem_q[rd_addr[IdxW-1:0]];
    if (ctl_i.mv_down) mem_q[wr_addr] <= rd_q;
    else if (ctl_i.mv_up) mem_q[wr_addr] <= rd_q;
    else if (ctl_i.put) mem_q[wr_addr] <= new_q;
  end

  assign refile = {1'b0, rd_q.due} + {1'b0, rd_q.ival};

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q <= opcode_i;
      new_q.path <= path_number_i;
      new_q.stn  <= station_number_i;
      new_q.due  <= (first_time_i > time_q) ? first_time_i : time_q;
      new_q.ival <= period_i;
    end else if (ctl_i.take_head) begin
      new_q.path <= rd_q.path;
      new_q.stn  <= rd_q.stn;
      new_q.due  <= refile[TimeW] ? '1 : refile[TimeW-1:0];
      new_q.ival <= rd_q.ival;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      cnt_q  <= '0;
      mark_q <= '0;
      time_q <= '0;
      disp_q <= 1'b0;
      stat_q <= ST_OK;
    end else begin
      if (ctl_i.idx_clr) idx_q <= '0;
      else if (ctl_i.idx_top) idx_q <= cnt_q;
      else if (ctl_i.idx_inc) idx_q <= idx_p1[CntW-1:0];
      else if (ctl_i.mv_up) idx_q <= idx_q - 1'b1;
      else if (ctl_i.mv_down) idx_q <= idx_p1[CntW-1:0];
      if (ctl_i.mark) mark_q <= idx_q;
      if (ctl_i.cnt_clr) cnt_q <= '0;
      else if (ctl_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      else if (ctl_i.cnt_dec) cnt_q <= cnt_q - 1'b1;
      if (ctl_i.time_inc) time_q <= time_q + 1'b1;
      if (ctl_i.latch) begin
        disp_q <= 1'b0;
        stat_q <= ST_OK;
      end else begin
        if (ctl_i.disp_set) disp_q <= 1'b1;
        if (ctl_i.set_nf) stat_q <= ST_NOTFOUND;
        if (ctl_i.set_full) stat_q <= ST_FULL;
      end
    end
  end

  assign sts_o.idx_end  = (idx_q == cnt_q);
  assign sts_o.idx_last = (idx_p1 == {1'b0, cnt_q});
  assign sts_o.idx_mark = (idx_q == mark_q);
  assign sts_o.path_hit = (rd_q.path == new_q.path);
  assign sts_o.due_lt   = (rd_q.due < new_q.due);
  assign sts_o.head_due = (time_q >= rd_q.due);
  assign sts_o.full     = (cnt_q == CntW'(MaxEntries));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.op       = op_q;

  assign done_o           = ctl_i.done;
  assign dispatched_o     = ctl_i.done & disp_q;
  assign out_path_o       = (ctl_i.done & disp_q) ? new_q.path : '0;
  assign out_station_o    = (ctl_i.done & disp_q) ? new_q.stn : '0;
  assign status_o         = ctl_i.done ? stat_q : ST_OK;
  assign entries_in_use_o = 7'(cnt_q);
endmodule
`default_nettype wire
